// ----- rtl/otgs_pkg.sv -----
// Shared types, constants and font lookup for the OLED text glyph streamer.
package otgs_pkg;

  // Input beat: one character of a text string.
  typedef struct packed {
    logic       first_of_string;
    logic [6:0] start_column;
    logic [2:0] page_row;
    logic [7:0] char_code;
  } in_t;

  // Output beat: one byte for the panel controller.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       last_of_run;
  } out_t;

  // One shown character, ready to be serialised into nine bytes.
  typedef struct packed {
    logic [2:0] page;
    logic [6:0] column;
    logic [4:0] glyph;
  } run_t;

  localparam logic [7:0] ColLimit   = 8'd122;
  localparam logic [7:0] ColStep    = 8'd6;
  localparam logic [7:0] CmdPage    = 8'hB0;
  localparam logic [7:0] CmdColLow  = 8'h00;
  localparam logic [7:0] CmdColHigh = 8'h10;
  localparam logic [7:0] GapByte    = 8'h00;

  // Byte slots within a character's run.
  localparam logic [3:0] SlotPage   = 4'd0;
  localparam logic [3:0] SlotColLo  = 4'd1;
  localparam logic [3:0] SlotColHi  = 4'd2;
  localparam logic [3:0] SlotGlyph0 = 4'd3;
  localparam logic [3:0] SlotGlyph4 = 4'd7;
  localparam logic [3:0] SlotGap    = 4'd8;

  localparam int unsigned GlyphCount = 30;
  localparam int unsigned GlyphCols  = 5;

  localparam logic [7:0] GlyphRom [GlyphCount][GlyphCols] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // blank
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, // 0
    '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00}, // 1
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, // 2
    '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31}, // 3
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, // 4
    '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39}, // 5
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, // 6
    '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03}, // 7
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, // 8
    '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}, // 9
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, // A
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, // C
    '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C}, // D
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, // E
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01}, // F
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, // I
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, // K
    '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, // L
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, // M
    '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F}, // N
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, // O
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, // Q
    '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46}, // R
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, // S
    '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}, // T
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, // U
    '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F}, // V
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, // Y
    '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}  // colon
  };

  // Character code to font row; unknown codes map to the blank glyph.
  function automatic logic [4:0] glyph_index(input logic [7:0] code);
    logic [7:0] digit;
    logic [4:0] idx;
    digit = code - 8'h30;
    case (code) inside
      [8'h30:8'h39]: idx = 5'd1 + digit[4:0];
      8'h41:         idx = 5'd11; // A
      8'h43:         idx = 5'd12; // C
      8'h44:         idx = 5'd13; // D
      8'h45:         idx = 5'd14; // E
      8'h46:         idx = 5'd15; // F
      8'h49:         idx = 5'd16; // I
      8'h4B:         idx = 5'd17; // K
      8'h4C:         idx = 5'd18; // L
      8'h4D:         idx = 5'd19; // M
      8'h4E:         idx = 5'd20; // N
      8'h4F:         idx = 5'd21; // O
      8'h51:         idx = 5'd22; // Q
      8'h52:         idx = 5'd23; // R
      8'h53:         idx = 5'd24; // S
      8'h54:         idx = 5'd25; // T
      8'h55:         idx = 5'd26; // U
      8'h56:         idx = 5'd27; // V
      8'h59:         idx = 5'd28; // Y
      8'h3A:         idx = 5'd29; // colon
      default:       idx = 5'd0;
    endcase
    return idx;
  endfunction

endpackage

// ----- rtl/oled_text_glyph_streamer.sv -----
// Top level: text string to OLED position commands and 5x7 glyph bytes.
// The first output beat of a shown character passes the holding, active-run and output registers.
// Each shown character leaves as nine bytes through the one-byte output register;
// an input beat that shows nothing produces no run.
// A run waits in a one-deep holding register while the previous run drains.
// Reset (rst_ni low, asynchronous) clears column, page, string state and all valids.
module oled_text_glyph_streamer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  otgs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output otgs_pkg::out_t out_data_o
);

  // string position state
  logic [7:0] cur_column_q, cur_column_d;
  logic [2:0] cur_page_q, cur_page_d;
  logic       string_active_q, string_active_d;

  // holding register for one decoded character run
  logic           pend_valid_q, pend_valid_d;
  otgs_pkg::run_t pend_q, pend_d;

  logic       in_accept;
  logic       run_take;
  logic       pend_take;
  logic [7:0] col_eff;
  logic [2:0] page_eff;
  logic       active_eff;
  logic       show;

  // A waiting run is only blocking when the serialiser cannot take it now.
  assign in_stall_o = pend_valid_q && !run_take;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pend_take  = pend_valid_q && run_take;

  // first_of_string reloads the position before the end-of-string check
  assign col_eff    = in_data_i.first_of_string ? {1'b0, in_data_i.start_column}
                                                : cur_column_q;
  assign page_eff   = in_data_i.first_of_string ? in_data_i.page_row : cur_page_q;
  assign active_eff = in_data_i.first_of_string || string_active_q;
  // zero code or a column past the limit ends the string silently
  assign show       = active_eff && (in_data_i.char_code != 8'd0)
                      && (col_eff <= otgs_pkg::ColLimit);

  always_comb begin
    cur_column_d    = cur_column_q;
    cur_page_d      = cur_page_q;
    string_active_d = string_active_q;
    pend_valid_d    = pend_valid_q && !pend_take;
    pend_d          = pend_q;
    if (in_accept) begin
      cur_column_d    = show ? (col_eff + otgs_pkg::ColStep) : col_eff;
      cur_page_d      = page_eff;
      string_active_d = show;
      if (show) begin
        pend_valid_d = 1'b1;
        pend_d.page   = page_eff;
        pend_d.column = col_eff[6:0];
        pend_d.glyph  = otgs_pkg::glyph_index(in_data_i.char_code);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_column_q    <= 8'd0;
      cur_page_q      <= 3'd0;
      string_active_q <= 1'b0;
      pend_valid_q    <= 1'b0;
    end else begin
      cur_column_q    <= cur_column_d;
      cur_page_q      <= cur_page_d;
      string_active_q <= string_active_d;
      pend_valid_q    <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  otgs_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (pend_valid_q),
    .run_i       (pend_q),
    .run_take_o  (run_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a waiting run is not dropped unless handed on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && !pend_take) |=> (pend_valid_q && $stable(pend_q)))
    else $error("held run lost or changed");

  // a shown character never leaves the column beyond the limit plus one step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && show) |=> (cur_column_q <= (otgs_pkg::ColLimit + otgs_pkg::ColStep)))
    else $error("column advanced beyond range");

  // an inactive string only comes alive through a first beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!string_active_q && !(in_accept && in_data_i.first_of_string)) |=> !string_active_q)
    else $error("string revived without first beat");

endmodule

// ----- rtl/otgs_serializer.sv -----
// Turns one character run into nine output beats through a registered output.
module otgs_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             run_valid_i,
  input  otgs_pkg::run_t   run_i,
  output logic             run_take_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output otgs_pkg::out_t   out_data_o
);

  logic           act_valid_q, act_valid_d;
  otgs_pkg::run_t act_q, act_d;
  logic [3:0]     slot_q, slot_d;
  logic           out_valid_q, out_valid_d;
  otgs_pkg::out_t out_q, out_d;

  logic           out_load;
  logic           act_free;
  logic [3:0]     col_off;
  otgs_pkg::out_t beat;

  assign out_load = act_valid_q && (!out_valid_q || !out_stall_i);
  assign act_free = !act_valid_q || (out_load && (slot_q == otgs_pkg::SlotGap));
  assign run_take_o = act_free;

  assign col_off = slot_q - otgs_pkg::SlotGlyph0;

  // byte for the current slot
  always_comb begin
    beat = '0;
    case (slot_q) inside
      otgs_pkg::SlotPage: begin
        beat.out_byte   = otgs_pkg::CmdPage | {5'd0, act_q.page};
        beat.is_command = 1'b1;
      end
      otgs_pkg::SlotColLo: begin
        beat.out_byte   = otgs_pkg::CmdColLow | {4'd0, act_q.column[3:0]};
        beat.is_command = 1'b1;
      end
      otgs_pkg::SlotColHi: begin
        beat.out_byte   = otgs_pkg::CmdColHigh | {5'd0, act_q.column[6:4]};
        beat.is_command = 1'b1;
      end
      [otgs_pkg::SlotGlyph0:otgs_pkg::SlotGlyph4]: begin
        beat.out_byte = otgs_pkg::GlyphRom[act_q.glyph][col_off[2:0]];
      end
      default: begin
        beat.out_byte    = otgs_pkg::GapByte;
        beat.last_of_run = 1'b1;
      end
    endcase
  end

  always_comb begin
    act_valid_d = act_valid_q;
    act_d       = act_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = beat;
      slot_d      = slot_q + 4'd1;
    end
    if (act_free) begin
      act_valid_d = run_valid_i;
      act_d       = run_i;
      slot_d      = otgs_pkg::SlotPage;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q <= 1'b0;
      slot_q      <= otgs_pkg::SlotPage;
      out_valid_q <= 1'b0;
    end else begin
      act_valid_q <= act_valid_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // slot never runs past the gap byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_valid_q |-> (slot_q <= otgs_pkg::SlotGap))
    else $error("slot counter beyond run length");

  // loading the gap slot yields the run's closing beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && slot_q == otgs_pkg::SlotGap) |=>
      (out_valid_q && out_q.last_of_run && !out_q.is_command))
    else $error("gap slot did not close the run");

  // a command beat is never the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_command) |-> !out_q.last_of_run)
    else $error("command beat flagged as last");

endmodule
